/* design/sqtw_pkg.sv */
`timescale 1ns / 1ps

package sqtw_pkg;

	localparam int CAPACITY     = 16;
	localparam int TASK_ID_BITS = 8;
	localparam int TICK_BITS    = 16;

	localparam int KIND_W     = 2;
	localparam int ID_IN_W    = 8;
	localparam int TICKS_IN_W = 16;
	localparam int EV_W       = 3;
	localparam int TASK_OUT_W = 8;
	localparam int OCC_W      = 7;

	localparam int IDX_W      = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int CNT_W      = $clog2(CAPACITY + 1);
	localparam int ENTRY_W    = TASK_ID_BITS + TICK_BITS;
	localparam int ID_EXT_W   = (TASK_ID_BITS > ID_IN_W) ? TASK_ID_BITS : ID_IN_W;
	localparam int TICK_EXT_W = (TICK_BITS > TICKS_IN_W) ? TICK_BITS : TICKS_IN_W;

	localparam logic [KIND_W-1:0] KIND_INSERT = KIND_W'(0);
	localparam logic [KIND_W-1:0] KIND_REMOVE = KIND_W'(1);
	localparam logic [KIND_W-1:0] KIND_TICK   = KIND_W'(2);

	typedef logic [IDX_W-1:0]        idx_t;
	typedef logic [CNT_W-1:0]        cnt_t;
	typedef logic [TASK_ID_BITS-1:0] task_t;
	typedef logic [TICK_BITS-1:0]    tick_t;

	typedef enum logic [EV_W-1:0] {
		EV_INSERTED  = 3'd0,
		EV_FULL      = 3'd1,
		EV_REMOVED   = 3'd2,
		EV_EMPTY     = 3'd3,
		EV_WOKEN     = 3'd4,
		EV_IDLE_TICK = 3'd5
	} ev_t;

	typedef enum logic [2:0] {
		EM_NONE,
		EM_INS,
		EM_FULL,
		EM_REM,
		EM_EMPTY,
		EM_WAKE,
		EM_NOWAKE
	} emit_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_INS,
		ST_REM_RD,
		ST_REM_EMIT,
		ST_A_RD,
		ST_A_CHK,
		ST_B_RD,
		ST_B_PROC,
		ST_END
	} state_t;

	typedef struct packed {
		logic  capture;
		logic  clr_idx;
		logic  restart;
		logic  ram_rd;
		logic  inc_idx;
		logic  cnt_wake;
		logic  wr_ins;
		logic  wr_surv;
		logic  pop;
		logic  commit_tick;
		emit_t emit;
	} cmd_t;

	typedef struct packed {
		logic count_zero;
		logic full;
		logic idx_end;
		logic woken;
		logic wk_zero;
		logic out_free;
	} sts_t;

	// ring index of base + off, off at most CAPACITY
	function automatic idx_t ring_add(idx_t base, cnt_t off);
		logic [CNT_W:0] sum;
		sum = (CNT_W + 1)'(base) + (CNT_W + 1)'(off);
		if (sum >= (CNT_W + 1)'(CAPACITY)) begin
			sum = sum - (CNT_W + 1)'(CAPACITY);
		end
		return sum[IDX_W-1:0];
	endfunction

endpackage

/* design/sqtw_req_if.sv */
`timescale 1ns / 1ps

interface sqtw_req_if;
	import sqtw_pkg::*;

	logic                  valid;
	logic                  ready;
	logic [KIND_W-1:0]     kind;
	logic [ID_IN_W-1:0]    task_id;
	logic [TICKS_IN_W-1:0] sleep_ticks;

	modport source (output valid, kind, task_id, sleep_ticks, input ready);
	modport sink   (input valid, kind, task_id, sleep_ticks, output ready);

endinterface

/* design/sqtw_rsp_if.sv */
`timescale 1ns / 1ps

interface sqtw_rsp_if;
	import sqtw_pkg::*;

	logic                  valid;
	logic                  ready;
	logic [EV_W-1:0]       event_res;
	logic [TASK_OUT_W-1:0] task_out;
	logic                  last;
	logic [OCC_W-1:0]      occupancy;

	modport source (output valid, event_res, task_out, last, occupancy, input ready);
	modport sink   (input valid, event_res, task_out, last, occupancy, output ready);

endinterface

/* design/sqtw_ram.sv */
`timescale 1ns / 1ps

module sqtw_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

/* design/sqtw_ctrl.sv */
`timescale 1ns / 1ps

module sqtw_ctrl (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	input  logic [sqtw_pkg::KIND_W-1:0] in_kind,
	output logic                      in_ready,
	input  sqtw_pkg::sts_t            sts,
	output sqtw_pkg::cmd_t            cmd
);
	import sqtw_pkg::*;

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					if (in_kind == KIND_INSERT) begin
						state_d = ST_INS;
					end else if (in_kind == KIND_REMOVE) begin
						state_d = ST_REM_RD;
					end else if (in_kind == KIND_TICK) begin
						state_d = ST_A_RD;
					end
				end
			end
			ST_INS: begin
				if (sts.out_free) begin
					state_d = ST_IDLE;
				end
			end
			ST_REM_RD: begin
				if (!sts.count_zero) begin
					state_d = ST_REM_EMIT;
				end else if (sts.out_free) begin
					state_d = ST_IDLE;
				end
			end
			ST_REM_EMIT: begin
				if (sts.out_free) begin
					state_d = ST_IDLE;
				end
			end
			ST_A_RD: begin
				state_d = sts.idx_end ? ST_B_RD : ST_A_CHK;
			end
			ST_A_CHK: begin
				state_d = ST_A_RD;
			end
			ST_B_RD: begin
				state_d = sts.idx_end ? ST_END : ST_B_PROC;
			end
			ST_B_PROC: begin
				if (!sts.woken || sts.out_free) begin
					state_d = ST_B_RD;
				end
			end
			ST_END: begin
				if (!sts.wk_zero || sts.out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_comb begin
		cmd      = '0;
		in_ready = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.capture = 1'b1;
					cmd.clr_idx = 1'b1;
				end
			end
			ST_INS: begin
				if (sts.out_free) begin
					if (sts.full) begin
						cmd.emit = EM_FULL;
					end else begin
						cmd.wr_ins = 1'b1;
						cmd.emit   = EM_INS;
					end
				end
			end
			ST_REM_RD: begin
				if (!sts.count_zero) begin
					cmd.ram_rd = 1'b1;
				end else if (sts.out_free) begin
					cmd.emit = EM_EMPTY;
				end
			end
			ST_REM_EMIT: begin
				if (sts.out_free) begin
					cmd.emit = EM_REM;
					cmd.pop  = 1'b1;
				end
			end
			ST_A_RD: begin
				if (sts.idx_end) begin
					cmd.restart = 1'b1;
				end else begin
					cmd.ram_rd = 1'b1;
				end
			end
			ST_A_CHK: begin
				cmd.cnt_wake = 1'b1;
				cmd.inc_idx  = 1'b1;
			end
			ST_B_RD: begin
				if (!sts.idx_end) begin
					cmd.ram_rd = 1'b1;
				end
			end
			ST_B_PROC: begin
				if (sts.woken) begin
					if (sts.out_free) begin
						cmd.emit    = EM_WAKE;
						cmd.inc_idx = 1'b1;
					end
				end else begin
					cmd.wr_surv = 1'b1;
					cmd.inc_idx = 1'b1;
				end
			end
			ST_END: begin
				if (!sts.wk_zero) begin
					cmd.commit_tick = 1'b1;
				end else if (sts.out_free) begin
					cmd.emit        = EM_NOWAKE;
					cmd.commit_tick = 1'b1;
				end
			end
			default: begin
				cmd = '0;
			end
		endcase
	end

endmodule

/* design/sqtw_dp.sv */
`timescale 1ns / 1ps

module sqtw_dp (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic [sqtw_pkg::ID_IN_W-1:0]    task_id,
	input  logic [sqtw_pkg::TICKS_IN_W-1:0] sleep_ticks,
	input  sqtw_pkg::cmd_t                cmd,
	output sqtw_pkg::sts_t                sts,
	sqtw_rsp_if.source                    rsp
);
	import sqtw_pkg::*;

	// ring state
	idx_t  head_q;
	cnt_t  count_q;
	// walk counters: read index, survivor write index, wakes found, wakes sent
	cnt_t  idx_q;
	cnt_t  wr_q;
	cnt_t  wk_q;
	cnt_t  ws_q;
	task_t id_q;
	tick_t ticks_q;

	logic                  out_valid_q;
	logic [EV_W-1:0]       ev_q;
	logic [TASK_OUT_W-1:0] task_q;
	logic                  last_q;
	logic [OCC_W-1:0]      occ_q;

	logic [ID_EXT_W-1:0]   id_ext;
	logic [TICK_EXT_W-1:0] ticks_ext;

	logic               ram_we;
	idx_t               ram_waddr;
	logic [ENTRY_W-1:0] ram_wdata;
	idx_t               ram_raddr;
	logic [ENTRY_W-1:0] ram_rdata;

	task_t rd_task;
	tick_t rd_tick;
	tick_t rd_dec;
	logic  rd_woken;
	logic  out_free;

	ev_t   ev_d;
	task_t task_d;
	logic  last_d;
	cnt_t  occ_d;

	assign id_ext    = ID_EXT_W'(task_id);
	assign ticks_ext = TICK_EXT_W'(sleep_ticks);

	assign rd_task  = ram_rdata[ENTRY_W-1 -: TASK_ID_BITS];
	assign rd_tick  = ram_rdata[TICK_BITS-1:0];
	assign rd_woken = (rd_tick == TICK_BITS'(1));
	assign rd_dec   = (rd_tick == '0) ? '0 : rd_tick - TICK_BITS'(1);

	assign out_free = !out_valid_q || rsp.ready;

	assign ram_raddr = ring_add(head_q, idx_q);
	assign ram_we    = cmd.wr_ins || cmd.wr_surv;

	always_comb begin
		if (cmd.wr_surv) begin
			ram_waddr = ring_add(head_q, wr_q);
			ram_wdata = {rd_task, rd_dec};
		end else begin
			ram_waddr = ring_add(head_q, count_q);
			ram_wdata = {id_q, ticks_q};
		end
	end

	sqtw_ram #(
		.WIDTH (ENTRY_W),
		.DEPTH (CAPACITY)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (cmd.ram_rd),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	always_comb begin
		sts.count_zero = (count_q == '0);
		sts.full       = (count_q == cnt_t'(CAPACITY));
		sts.idx_end    = (idx_q == count_q);
		sts.woken      = rd_woken;
		sts.wk_zero    = (wk_q == '0);
		sts.out_free   = out_free;
	end

	always_comb begin
		ev_d   = EV_INSERTED;
		task_d = '0;
		last_d = 1'b1;
		occ_d  = count_q;
		case (cmd.emit)
			EM_INS: begin
				ev_d  = EV_INSERTED;
				occ_d = count_q + cnt_t'(1);
			end
			EM_FULL: begin
				ev_d = EV_FULL;
			end
			EM_REM: begin
				ev_d   = EV_REMOVED;
				task_d = rd_task;
				occ_d  = count_q - cnt_t'(1);
			end
			EM_EMPTY: begin
				ev_d = EV_EMPTY;
			end
			EM_WAKE: begin
				ev_d   = EV_WOKEN;
				task_d = rd_task;
				last_d = (cnt_t'(ws_q + cnt_t'(1)) == wk_q);
				occ_d  = count_q - wk_q;
			end
			EM_NOWAKE: begin
				ev_d = EV_IDLE_TICK;
			end
			default: begin
				ev_d = EV_INSERTED;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q      <= '0;
			count_q     <= '0;
			idx_q       <= '0;
			wr_q        <= '0;
			wk_q        <= '0;
			ws_q        <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.clr_idx) begin
				idx_q <= '0;
				wr_q  <= '0;
				wk_q  <= '0;
				ws_q  <= '0;
			end else if (cmd.restart) begin
				idx_q <= '0;
				wr_q  <= '0;
				ws_q  <= '0;
			end else begin
				if (cmd.inc_idx) begin
					idx_q <= idx_q + cnt_t'(1);
				end
				if (cmd.wr_surv) begin
					wr_q <= wr_q + cnt_t'(1);
				end
				if (cmd.cnt_wake && rd_woken) begin
					wk_q <= wk_q + cnt_t'(1);
				end
				if (cmd.emit == EM_WAKE) begin
					ws_q <= ws_q + cnt_t'(1);
				end
			end
			if (cmd.wr_ins) begin
				count_q <= count_q + cnt_t'(1);
			end else if (cmd.pop) begin
				count_q <= count_q - cnt_t'(1);
				head_q  <= ring_add(head_q, cnt_t'(1));
			end else if (cmd.commit_tick) begin
				count_q <= wr_q;
			end
			if (cmd.emit != EM_NONE) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			id_q    <= id_ext[TASK_ID_BITS-1:0];
			ticks_q <= ticks_ext[TICK_BITS-1:0];
		end
		if (cmd.emit != EM_NONE) begin
			ev_q   <= ev_d;
			task_q <= TASK_OUT_W'(ID_EXT_W'(task_d));
			last_q <= last_d;
			occ_q  <= OCC_W'(occ_d);
		end
	end

	assign rsp.valid     = out_valid_q;
	assign rsp.event_res = ev_q;
	assign rsp.task_out  = task_q;
	assign rsp.last      = last_q;
	assign rsp.occupancy = occ_q;

`ifndef ASSERT_OFF
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= cnt_t'(CAPACITY))
		else $error("occupancy above capacity");

	a_emit_free: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.emit != EM_NONE) |-> out_free)
		else $error("result written over a stalled beat");

	a_compact_order: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.wr_surv |-> (wr_q <= idx_q))
		else $error("survivor write passed the read index");

	a_wake_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.emit == EM_WAKE) |-> (ws_q < wk_q))
		else $error("more wakes sent than counted");

	a_commit_count: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.commit_tick |=> (count_q == $past(wr_q)))
		else $error("tick commit lost the survivor count");
`endif

endmodule

/* design/sleep_queue_tick_waker.sv */
`timescale 1ns / 1ps

// Sleep queue with tick wakeup.
// req channel: one beat per command (kind 0 insert task_id/sleep_ticks,
// kind 1 pop head, kind 2 timer tick; kind 3 is dropped with no result).
// rsp channel: one beat per result; last marks the final beat of a
// command and occupancy is the queue fill after the whole command.
// Entries sit in a ring buffer RAM (one read, one write port); a tick walks
// the ring twice, first counting expiries, then compacting survivors and
// sending woken tasks in queue order.
// One command is in flight at a time; req.ready is high only between
// commands.
// Reset clears the queue to empty and drops any pending rsp beat.
// A stalled rsp beat holds; the walk pauses on the next result until the
// output register frees up.
module sleep_queue_tick_waker (
	input  logic       clk,
	input  logic       arst_n,
	sqtw_req_if.sink   req,
	sqtw_rsp_if.source rsp
);
	import sqtw_pkg::*;

	cmd_t cmd;
	sts_t sts;

	sqtw_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (req.valid),
		.in_kind  (req.kind),
		.in_ready (req.ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	sqtw_dp u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.task_id     (req.task_id),
		.sleep_ticks (req.sleep_ticks),
		.cmd         (cmd),
		.sts         (sts),
		.rsp         (rsp)
	);

endmodule

/* bench/testbench.sv */
`timescale 1ns / 1ps

module testbench;
	import sqtw_pkg::*;

	localparam logic [KIND_W-1:0] KIND_UNUSED = KIND_W'(3);
	localparam int CYCLE_LIMIT = 1000000;
	localparam int RANDOM_CMDS = 405;
	localparam int DRAIN_CYCLES = 200;

	typedef struct {
		logic [KIND_W-1:0]     kind;
		logic [ID_IN_W-1:0]    task_id;
		logic [TICKS_IN_W-1:0] sleep_ticks;
		int                    phase;
	} sleep_cmd_t;

	typedef struct {
		ev_t                   ev;
		logic [TASK_OUT_W-1:0] task_out;
		logic                  last;
		logic [OCC_W-1:0]      occupancy;
	} sleep_result_t;

	logic clk;
	logic arst_n;

	sqtw_req_if req_ch();
	sqtw_rsp_if rsp_ch();

	sleep_queue_tick_waker i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch)
	);

	// per phase: none, sender idle, receiver stall, both
	int send_idle_pct[4] = '{0, 48, 0, 23};
	int rsp_stall_pct[4] = '{0, 0, 48, 23};

	sleep_cmd_t    pending_cmds[$];
	sleep_result_t results_due[$];
	sleep_cmd_t    on_bus;
	int            cur_phase = 0;
	int            errors = 0;
	int            cycles = 0;

	task_t q_task[CAPACITY];
	tick_t q_left[CAPACITY];
	int    q_count = 0;

	function automatic void queue_cmd(logic [KIND_W-1:0] kind, logic [ID_IN_W-1:0] id,
		logic [TICKS_IN_W-1:0] ticks, int phase);
		sleep_cmd_t c;
		c.kind = kind;
		c.task_id = id;
		c.sleep_ticks = ticks;
		c.phase = phase;
		pending_cmds.push_back(c);
	endfunction

	function automatic void advance_sleep_queue(sleep_cmd_t c);
		sleep_result_t r[$];
		tick_t left;
		int keep;
		if (c.kind == KIND_INSERT) begin
			if (q_count >= CAPACITY) begin
				r.push_back('{EV_FULL, '0, 1'b0, '0});
			end else begin
				q_task[q_count] = task_t'(c.task_id);
				q_left[q_count] = tick_t'(c.sleep_ticks);
				q_count++;
				r.push_back('{EV_INSERTED, '0, 1'b0, '0});
			end
		end else if (c.kind == KIND_REMOVE) begin
			if (q_count == 0) begin
				r.push_back('{EV_EMPTY, '0, 1'b0, '0});
			end else begin
				r.push_back('{EV_REMOVED, TASK_OUT_W'(q_task[0]), 1'b0, '0});
				for (int i = 1; i < q_count; i++) begin
					q_task[i-1] = q_task[i];
					q_left[i-1] = q_left[i];
				end
				q_count--;
			end
		end else if (c.kind == KIND_TICK) begin
			keep = 0;
			for (int i = 0; i < q_count; i++) begin
				left = q_left[i];
				if (left != 0) begin
					left = left - 1'b1;
					if (left == 0) begin
						r.push_back('{EV_WOKEN, TASK_OUT_W'(q_task[i]), 1'b0, '0});
						continue;
					end
				end
				q_task[keep] = q_task[i];
				q_left[keep] = left;
				keep++;
			end
			q_count = keep;
			if (r.size() == 0) begin
				r.push_back('{EV_IDLE_TICK, '0, 1'b0, '0});
			end
		end else begin
			return;
		end
		foreach (r[k]) begin
			r[k].last = (k == r.size() - 1);
			r[k].occupancy = OCC_W'(q_count);
			results_due.push_back(r[k]);
		end
	endfunction

	task automatic report_mismatch(string msg);
		errors++;
		$display("%0t mismatch: %s", $realtime, msg);
	endtask

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("TB_ERROR");
			$finish;
		end
	end

	// driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_ch.valid <= 1'b0;
			req_ch.kind <= '0;
			req_ch.task_id <= '0;
			req_ch.sleep_ticks <= '0;
		end else begin
			if (req_ch.valid && req_ch.ready) begin
				advance_sleep_queue(on_bus);
			end
			if (!req_ch.valid || req_ch.ready) begin
				if (pending_cmds.size() > 0 &&
					$urandom_range(99) >= send_idle_pct[cur_phase]) begin
					on_bus = pending_cmds.pop_front();
					cur_phase = on_bus.phase;
					req_ch.valid <= 1'b1;
					req_ch.kind <= on_bus.kind;
					req_ch.task_id <= on_bus.task_id;
					req_ch.sleep_ticks <= on_bus.sleep_ticks;
				end else begin
					req_ch.valid <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_ch.ready <= 1'b0;
		end else begin
			rsp_ch.ready <= ($urandom_range(99) >= rsp_stall_pct[cur_phase]);
		end
	end

	// monitor
	always @(posedge clk) begin
		sleep_result_t want;
		if (arst_n && rsp_ch.valid && rsp_ch.ready) begin
			if (results_due.size() == 0) begin
				report_mismatch($sformatf("unexpected beat, event %0d task %0d",
					rsp_ch.event_res, rsp_ch.task_out));
			end else begin
				want = results_due.pop_front();
				if (rsp_ch.event_res !== want.ev)
					report_mismatch($sformatf("event_res got %0d want %0d",
						rsp_ch.event_res, want.ev));
				if (rsp_ch.task_out !== want.task_out)
					report_mismatch($sformatf("task_out got %0d want %0d",
						rsp_ch.task_out, want.task_out));
				if (rsp_ch.last !== want.last)
					report_mismatch($sformatf("last got %0d want %0d",
						rsp_ch.last, want.last));
				if (rsp_ch.occupancy !== want.occupancy)
					report_mismatch($sformatf("occupancy got %0d want %0d",
						rsp_ch.occupancy, want.occupancy));
			end
		end
	end

	initial begin
		int n_real;
		int mode;
		int pick;
		int phase;
		logic [KIND_W-1:0] kind;
		logic [TICKS_IN_W-1:0] ticks;

		arst_n = 1'b0;

		// fill with a never-waking entry, a max-count entry and short sleepers
		queue_cmd(KIND_INSERT, 8'h00, 16'h0000, 0);
		queue_cmd(KIND_INSERT, 8'hFF, 16'hFFFF, 0);
		for (int i = 0; i < CAPACITY - 2; i++) begin
			queue_cmd(KIND_INSERT, ID_IN_W'(8'h11 * (i + 1)),
				(i % 2) ? 16'd2 : 16'd1, 0);
		end
		queue_cmd(KIND_INSERT, 8'hA5, 16'd3, 0);
		queue_cmd(KIND_TICK, 8'h5A, 16'h1234, 0);
		queue_cmd(KIND_TICK, 8'h00, 16'h0000, 0);
		queue_cmd(KIND_TICK, 8'hFF, 16'hFFFF, 0);
		queue_cmd(KIND_REMOVE, 8'h3C, 16'h00FF, 0);
		queue_cmd(KIND_REMOVE, 8'h00, 16'h0000, 0);
		queue_cmd(KIND_REMOVE, 8'hC3, 16'hFF00, 0);
		queue_cmd(KIND_UNUSED, 8'hFF, 16'hFFFF, 0);
		queue_cmd(KIND_TICK, 8'h00, 16'h0000, 0);

		n_real = 0;
		while (n_real < RANDOM_CMDS) begin
			mode = (n_real / 30) % 3;
			phase = (n_real / 55) % 4;
			pick = $urandom_range(99);
			case (mode)
				0: kind = (pick < 70) ? KIND_INSERT : (pick < 88) ? KIND_TICK :
					(pick < 95) ? KIND_REMOVE : KIND_UNUSED;
				1: kind = (pick < 20) ? KIND_INSERT : (pick < 80) ? KIND_TICK :
					(pick < 95) ? KIND_REMOVE : KIND_UNUSED;
				default: kind = (pick < 25) ? KIND_INSERT : (pick < 45) ? KIND_TICK :
					(pick < 95) ? KIND_REMOVE : KIND_UNUSED;
			endcase
			pick = $urandom_range(99);
			if (pick < 8)
				ticks = '0;
			else if (pick < 80)
				ticks = TICKS_IN_W'($urandom_range(6, 1));
			else if (pick < 92)
				ticks = TICKS_IN_W'($urandom_range(40, 7));
			else
				ticks = TICKS_IN_W'($urandom_range(16'hFFFF));
			queue_cmd(kind, ID_IN_W'($urandom_range(255)), ticks, phase);
			if (kind != KIND_UNUSED)
				n_real++;
		end

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		while (pending_cmds.size() != 0 || req_ch.valid || results_due.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (errors == 0 && results_due.size() == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end

endmodule
